@@ rtl/mwf_pkg.sv @@
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types and constants for the median window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_W      = 11;
	localparam int KS_W       = 3;
	localparam int ROW_W      = 11;
	localparam int BIT_W      = 3;
	localparam int MAX_HEIGHT = 1024;

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_KERNEL = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_BORDER,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic sample;
		logic decide;
	} rank_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mwf_if.sv @@
// ----------------------------------------------------------------------------
// mwf_if
// Valid/ready channels for pixel input and filtered output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwf_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] pixel;
	modport source (output valid, output op, output pixel, input ready);
	modport sink (input valid, input op, input pixel, output ready);
endinterface

interface mwf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value;
	logic       frame_end;
	modport source (output valid, output value, output frame_end, input ready);
	modport sink (input valid, input value, input frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/mwf_ram.sv @@
// ----------------------------------------------------------------------------
// mwf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 7168
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/mwf_rank.sv @@
// ----------------------------------------------------------------------------
// mwf_rank
// Bit-serial rank selector: one compare/count per window sample, one
// decision per bit, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_rank
	import mwf_pkg::*;
#(
	parameter int CNT_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rank_ctl_t        ctl,
	input  wire logic [CNT_W-1:0] rank_init,
	input  wire logic [PIX_W-1:0] data,
	output logic      [PIX_W-1:0] median,
	output logic                  last_bit
);

	logic [PIX_W-1:0] prefix_q;
	logic [CNT_W-1:0] m_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BIT_W-1:0] bit_q;
	logic             eq;
	logic             hit;

	always_comb begin
		eq = 1'b1;
		for (int t = 0; t < PIX_W; t++) begin
			if (t > int'(bit_q) && data[t] != prefix_q[t]) begin
				eq = 1'b0;
			end
		end
		hit = eq && !data[bit_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			m_q      <= '0;
			cnt_q    <= '0;
			bit_q    <= BIT_W'(PIX_W - 1);
		end else if (ctl.start) begin
			prefix_q <= '0;
			m_q      <= rank_init;
			cnt_q    <= '0;
			bit_q    <= BIT_W'(PIX_W - 1);
		end else begin
			if (ctl.sample && hit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctl.decide) begin
				if (m_q >= cnt_q) begin
					prefix_q[bit_q] <= 1'b1;
					m_q             <= m_q - cnt_q;
				end
				cnt_q <= '0;
				if (bit_q != '0) begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	assign median   = prefix_q;
	assign last_bit = (bit_q == '0);

endmodule

`default_nettype wire

@@ rtl/median_window_filter.sv @@
// ----------------------------------------------------------------------------
// median_window_filter
// Streaming 2-D median filter for 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
// Each pixel is written to a line store of MAX_KERNEL rows; once enough rows
// are buffered the block gives the median of the K x K window around the
// oldest pending pixel, or that pixel itself where the window leaves the
// image. The median is picked MSB first by one shared compare/count unit that
// rereads the window from the line store once per bit. The input is not ready
// while a pixel is being computed. The result waits in an output register
// while the next item is taken. After the last pixel of a frame, flush
// transactions drain the pending outputs. An even kernel size suppresses all
// output. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module median_window_filter
	import mwf_pkg::*;
#(
	parameter int MAX_KERNEL = 7,
	parameter int MAX_WIDTH  = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	mwf_in_if.sink                in_ch,
	mwf_out_if.source             out_ch
);

	localparam int DEPTH    = MAX_KERNEL * MAX_WIDTH;
	localparam int AW       = $clog2(DEPTH);
	localparam int SW       = $clog2(MAX_KERNEL);
	localparam int KMAX_ODD = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
	localparam int CNT_W    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int PW       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int LAG_W    = CFG_W + KS_W;

	logic [KS_W-1:0]  kernel_size_q;
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	logic [KS_W-1:0]  keff;
	logic [KS_W-1:0]  h;
	logic [CFG_W-1:0] weff;
	logic [ROW_W-1:0] heff;
	logic [LAG_W-1:0] lag;
	logic [CNT_W-1:0] rank_init;
	logic             k_odd;

	logic [CFG_W-1:0] in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [SW-1:0]    in_slot_q, out_slot_q;
	logic [PW-1:0]    pend_q;

	state_t state_q, state_d;

	logic [KS_W-1:0]  wi_q, wj_q;
	logic [SW-1:0]    win_slot_q, win_slot0_q;
	logic [CFG_W-1:0] win_col_q, win_col0_q;
	logic             border_q;
	logic [PIX_W-1:0] res_q;
	logic             rd_vld_s1;

	logic             out_vld_q;
	logic [PIX_W-1:0] out_value_q;
	logic             out_fe_q;

	logic             cfg_hit;
	logic             in_acc;
	logic             done_in;
	logic             is_px;
	logic             ram_we;
	logic             emit_req;
	logic [CFG_W-1:0] col_inc;
	logic             col_wrap;
	logic [ROW_W-1:0] row_next;
	logic [PW-1:0]    pend_inc;

	logic             border;
	logic [SW-1:0]    slot_start;
	logic             last_issue;
	logic             issue;
	logic             out_free;
	logic             out_load;
	logic [CFG_W-1:0] oc_inc;
	logic             oc_wrap;
	logic [ROW_W-1:0] or_next;
	logic             frame_end;

	logic [SW-1:0]    rd_slot;
	logic [CFG_W-1:0] rd_col;
	logic [AW-1:0]    raddr, waddr;
	logic [PIX_W-1:0] rdata;

	rank_ctl_t        rctl;
	logic [PIX_W-1:0] median;
	logic             last_bit;

	// effective configuration
	always_comb begin
		if (32'(kernel_size_q) > MAX_KERNEL) begin
			keff = KS_W'(KMAX_ODD);
		end else begin
			keff = kernel_size_q;
		end
		if (image_width_q == '0) begin
			weff = CFG_W'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			weff = CFG_W'(MAX_WIDTH);
		end else begin
			weff = image_width_q;
		end
		if (image_height_q == '0) begin
			heff = ROW_W'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			heff = ROW_W'(MAX_HEIGHT);
		end else begin
			heff = ROW_W'(image_height_q);
		end
	end

	assign k_odd     = keff[0];
	assign h         = keff >> 1;
	assign lag       = LAG_W'(h) * LAG_W'(weff) + LAG_W'(h);
	assign rank_init = (CNT_W'(keff) * CNT_W'(keff)) >> 1;

	// configuration port
	always_comb begin
		unique case (cfg_index)
			CFG_KERNEL, CFG_WIDTH, CFG_HEIGHT: cfg_hit = cfg_we;
			default:                           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_size_q  <= KS_W'(3);
			image_width_q  <= CFG_W'(640);
			image_height_q <= CFG_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KERNEL: kernel_size_q  <= cfg_data[KS_W-1:0];
				CFG_WIDTH:  image_width_q  <= cfg_data;
				CFG_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input side
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign done_in     = (in_row_q >= heff);
	assign is_px       = (in_ch.op == OP_PIXEL) && !done_in;
	assign ram_we      = in_acc && k_odd && is_px;
	assign col_inc     = in_col_q + 1'b1;
	assign col_wrap    = (col_inc >= weff);
	assign row_next    = col_wrap ? in_row_q + 1'b1 : in_row_q;
	assign pend_inc    = pend_q + 1'b1;

	always_comb begin
		if (is_px) begin
			emit_req = k_odd && ((row_next >= heff) || (pend_inc > PW'(lag)));
		end else begin
			emit_req = k_odd && done_in && (pend_q != '0);
		end
	end

	// window geometry
	assign border = (out_row_q < ROW_W'(h)) || (out_col_q < CFG_W'(h)) ||
		({1'b0, out_row_q} + (ROW_W+1)'(h) >= {1'b0, heff}) ||
		({1'b0, out_col_q} + (CFG_W+1)'(h) >= {1'b0, weff});

	assign slot_start = (out_slot_q >= SW'(h)) ? out_slot_q - SW'(h) :
		out_slot_q + SW'(MAX_KERNEL) - SW'(h);

	assign last_issue = (wi_q == keff - 1'b1) && (wj_q == keff - 1'b1);

	// output side
	assign out_free  = !out_vld_q || out_ch.ready;
	assign out_load  = (state_q == ST_DONE) && out_free;
	assign oc_inc    = out_col_q + 1'b1;
	assign oc_wrap   = (oc_inc >= weff);
	assign or_next   = oc_wrap ? out_row_q + 1'b1 : out_row_q;
	assign frame_end = (or_next >= heff);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc && emit_req) state_d = ST_EVAL;
			ST_EVAL:   state_d = border ? ST_BORDER : ST_SCAN;
			ST_BORDER: state_d = ST_DONE;
			ST_SCAN:   if (last_issue) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = last_bit ? ST_DONE : ST_SCAN;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		issue       = 1'b0;
		rctl.start  = 1'b0;
		rctl.sample = rd_vld_s1;
		rctl.decide = 1'b0;
		rd_slot     = out_slot_q;
		rd_col      = out_col_q;
		unique case (state_q)
			ST_EVAL: rctl.start = 1'b1;
			ST_SCAN: begin
				issue   = 1'b1;
				rd_slot = win_slot_q;
				rd_col  = win_col_q;
			end
			ST_DECIDE: rctl.decide = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
		end
	end

	// window walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_EVAL: begin
				border_q    <= border;
				wi_q        <= '0;
				wj_q        <= '0;
				win_slot0_q <= slot_start;
				win_slot_q  <= slot_start;
				win_col0_q  <= out_col_q - CFG_W'(h);
				win_col_q   <= out_col_q - CFG_W'(h);
			end
			ST_BORDER: res_q <= rdata;
			ST_SCAN: begin
				if (wj_q == keff - 1'b1) begin
					wj_q      <= '0;
					win_col_q <= win_col0_q;
					wi_q      <= wi_q + 1'b1;
					if (win_slot_q == SW'(MAX_KERNEL - 1)) begin
						win_slot_q <= '0;
					end else begin
						win_slot_q <= win_slot_q + 1'b1;
					end
				end else begin
					wj_q      <= wj_q + 1'b1;
					win_col_q <= win_col_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				wi_q       <= '0;
				wj_q       <= '0;
				win_slot_q <= win_slot0_q;
				win_col_q  <= win_col0_q;
			end
			default: ;
		endcase
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else if (cfg_hit) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else begin
			if (ram_we) begin
				pend_q <= pend_inc;
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= row_next;
					if (in_slot_q == SW'(MAX_KERNEL - 1)) begin
						in_slot_q <= '0;
					end else begin
						in_slot_q <= in_slot_q + 1'b1;
					end
				end else begin
					in_col_q <= col_inc;
				end
			end
			if (out_load) begin
				if (frame_end) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
					pend_q     <= '0;
				end else begin
					pend_q <= pend_q - 1'b1;
					if (oc_wrap) begin
						out_col_q <= '0;
						out_row_q <= or_next;
						if (out_slot_q == SW'(MAX_KERNEL - 1)) begin
							out_slot_q <= '0;
						end else begin
							out_slot_q <= out_slot_q + 1'b1;
						end
					end else begin
						out_col_q <= oc_inc;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= border_q ? res_q : median;
			out_fe_q    <= frame_end;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.value     = out_value_q;
	assign out_ch.frame_end = out_fe_q;

	// line store
	assign waddr = AW'(int'(in_slot_q) * MAX_WIDTH) + AW'(in_col_q);
	assign raddr = AW'(int'(rd_slot) * MAX_WIDTH) + AW'(rd_col);

	mwf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (in_ch.pixel),
		.raddr (raddr),
		.rdata (rdata)
	);

	mwf_rank #(
		.CNT_W (CNT_W)
	) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rctl),
		.rank_init (rank_init),
		.data      (rdata),
		.median    (median),
		.last_bit  (last_bit)
	);

	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE)
		else $error("line store written outside idle");

	a_load_pend: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> pend_q != '0)
		else $error("result given with nothing pending");

	a_scan_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> k_odd)
		else $error("window scan with even kernel");

endmodule

`default_nettype wire
